>>> src/plasma_pixel_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the plasma pixel generator
// Shared wrappers for clocked implication checks with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef PLASMA_PIXEL_GENERATOR_UNIT_ASSERT_SVH
`define PLASMA_PIXEL_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PPG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("plasma pixel generator: check failed");

// Next-cycle implication, disabled while reset is low.
`define PPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("plasma pixel generator: check failed");

`endif

>>> src/ppg_pkg.sv
// ----------------------------------------------------------------------------
// ppg_pkg
// Widths, constants, pipeline control type and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package ppg_pkg;

    localparam int COEF_BITS   = 10;
    localparam int X_W         = 10;
    localparam int T_W         = 24;
    localparam int REG_BITS    = 60;
    localparam int NUM_REGS    = 6;
    localparam int NUM_CH      = 3;
    localparam int NUM_TERMS   = 4;
    localparam int NUM_LOOKUPS = NUM_CH * NUM_TERMS;

    // phase path
    localparam int AY_W        = COEF_BITS + X_W + 1;
    localparam int XY_W        = AY_W + 1;
    localparam int CT_W        = COEF_BITS + T_W + 1;
    localparam int P_W         = CT_W + 8;
    localparam int PHASE_SHIFT = COEF_BITS + 4;

    // sine table
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_AW      = 10;
    localparam int QUARTER_AW   = SINE_AW - 2;
    localparam int QUARTER_LEN  = SINE_ENTRIES / 4;
    localparam int MAG_W        = PHASE_SHIFT + SINE_AW;
    localparam int SINE_W       = 16;
    localparam int QMAG_W       = SINE_W - 1;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // level mapping
    localparam int SUM_W        = 18;
    localparam int LVL_W        = 6;
    localparam int LEVEL_SHIFT  = 17;
    localparam int PROD_W       = SUM_W + LVL_W;
    localparam int LEVEL_BIAS   = 65536;
    localparam logic [LVL_W-1:0] LEVEL_M [NUM_CH] = '{6'd63, 6'd15, 6'd31};

    typedef logic [REG_BITS-1:0] t_reg_bank [NUM_REGS];
    typedef logic [QUARTER_LEN-1:0][QMAG_W-1:0] t_qtab;

    // per-stage load enables, stage 1 nearest the input
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_adv;

    // Q1.14 sine over the first quarter turn, Q2.30 series to the x^13 term
    function automatic logic [QMAG_W-1:0] quarter_sine(input logic [63:0] rem);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = (rem * HALF_PI_Q30 + 64'(SINE_ENTRIES / 2)) / SINE_ENTRIES;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + signed'(term);
        if (sum < 0) begin
            sum = '0;
        end
        return QMAG_W'((sum + 64'sd32768) >>> 16);
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab tab;
        for (int k = 0; k < QUARTER_LEN; k++) begin
            tab[k] = quarter_sine(64'(4 * k));
        end
        return tab;
    endfunction

    localparam t_qtab QTAB = build_qtab();
    localparam logic [QMAG_W-1:0] QUARTER_PEAK = quarter_sine(64'(SINE_ENTRIES));

    // full-turn sine entry rebuilt from the quarter table by symmetry
    function automatic logic signed [SINE_W-1:0] sine_value(input logic [SINE_AW-1:0] idx);
        logic [QUARTER_AW-1:0] j;
        logic [QMAG_W-1:0]     mag;
        j = idx[QUARTER_AW-1:0];
        if (idx[QUARTER_AW]) begin
            mag = (j == '0) ? QUARTER_PEAK : QTAB[QUARTER_AW'(~j + QUARTER_AW'(1))];
        end else begin
            mag = QTAB[j];
        end
        return idx[QUARTER_AW+1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    endfunction

endpackage

>>> src/plasma_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// plasma_pixel_generator_unit
// Sum-of-sines plasma color for one pixel per clock while the receiver is ready.
//
// Usage: present pixel_x, pixel_y and frame_time on the pixel channel
// (i_pix_valid / o_pix_ready); the red, green and blue levels come out on the
// color channel (o_rgb_valid / i_rgb_ready) in the same order, one per item.
// Throughput is one item per clock while i_rgb_ready holds: six register
// stages (products, phase sum, index, sine lookup, channel sum, level
// scale), each with its own valid bit.
// Coefficients are written through the APB port, 64-bit data, register i at
// byte address 8*i; write them only while no item is in flight.
// Reset clears the coefficient registers and empties the pipeline.
// When the receiver stalls, the output item holds and the stages behind it
// keep filling bubbles; o_pix_ready drops only once every stage holds an item.
// ----------------------------------------------------------------------------
`include "plasma_pixel_generator_unit_assert.svh"

module plasma_pixel_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // pixel channel
    input  logic        i_pix_valid,
    output logic        o_pix_ready,
    input  logic [9:0]  i_pixel_x,
    input  logic [9:0]  i_pixel_y,
    input  logic [23:0] i_frame_time,
    // color channel
    output logic        o_rgb_valid,
    input  logic        i_rgb_ready,
    output logic [5:0]  o_red_level,
    output logic [3:0]  o_green_level,
    output logic [4:0]  o_blue_level
);

    localparam int NUM_STAGES = 6;
    localparam int RIDX_W     = 3;
    localparam int CH_RED     = 0;
    localparam int CH_GREEN   = 1;
    localparam int CH_BLUE    = 2;

    // ------------------------------------------------------------------
    // Coefficient registers
    // ------------------------------------------------------------------
    ppg_pkg::t_reg_bank         r_terms;
    logic [RIDX_W-1:0]          w_ridx;
    logic                       w_reg_hit;
    logic                       w_wr;

    assign pready    = 1'b1;
    assign w_ridx    = paddr[5:3];
    assign w_reg_hit = (w_ridx < RIDX_W'(ppg_pkg::NUM_REGS));
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ppg_pkg::NUM_REGS; i++) begin
                r_terms[i] <= '0;
            end
        end else if (w_wr && w_reg_hit) begin
            // drop writes past the last register
            r_terms[w_ridx] <= pwdata[ppg_pkg::REG_BITS-1:0];
        end
    end

    assign prdata = w_reg_hit ? 64'(r_terms[w_ridx]) : '0;

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or the next one
    // loads, so bubbles collapse while the output is stalled.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES:0]   w_rdy;
    logic [NUM_STAGES-1:0] w_vin;
    ppg_pkg::t_adv         w_adv;

    assign w_rdy[NUM_STAGES] = i_rgb_ready;
    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_rdy
        assign w_rdy[s] = !r_vld[s] || w_rdy[s + 1];
    end

    assign w_vin = {r_vld[NUM_STAGES-2:0], i_pix_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NUM_STAGES; s++) begin
                if (w_rdy[s]) begin
                    r_vld[s] <= w_vin[s];
                end
            end
        end
    end

    assign w_adv.s1 = w_rdy[0];
    assign w_adv.s2 = w_rdy[1];
    assign w_adv.s3 = w_rdy[2];
    assign w_adv.s4 = w_rdy[3];
    assign w_adv.s5 = w_rdy[4];
    assign w_adv.s6 = w_rdy[5];

    assign o_pix_ready = w_rdy[0];
    assign o_rgb_valid = r_vld[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic [ppg_pkg::SINE_AW-1:0]         w_idx   [ppg_pkg::NUM_LOOKUPS];
    logic signed [ppg_pkg::SINE_W-1:0]   w_sin   [ppg_pkg::NUM_LOOKUPS];
    logic [ppg_pkg::LVL_W-1:0]           w_level [ppg_pkg::NUM_CH];

    ppg_phase u_phase (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_terms (r_terms),
        .i_x     (i_pixel_x),
        .i_y     (i_pixel_y),
        .i_t     (i_frame_time),
        .o_idx   (w_idx)
    );

    ppg_sine u_sine (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_idx (w_idx),
        .o_sin (w_sin)
    );

    ppg_level u_level (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_sin   (w_sin),
        .o_level (w_level)
    );

    assign o_red_level   = w_level[CH_RED][5:0];
    assign o_green_level = w_level[CH_GREEN][3:0];
    assign o_blue_level  = w_level[CH_BLUE][4:0];

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `PPG_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n,
        i_pix_valid && o_pix_ready, r_vld[0])
    `PPG_ASSERT_IMPLY(a_stall_only_full, i_clk, i_rst_n,
        !o_pix_ready, &r_vld)
    `PPG_ASSERT_NEXT(a_drain_empty, i_clk, i_rst_n,
        o_rgb_valid && i_rgb_ready && !r_vld[NUM_STAGES-2], !o_rgb_valid)

endmodule

>>> src/ppg_phase.sv
// ----------------------------------------------------------------------------
// ppg_phase
// Stages 1-3: coefficient products, phase sum, magnitude and table index.
// ----------------------------------------------------------------------------
module ppg_phase (
    input  logic                         i_clk,
    input  ppg_pkg::t_adv                i_adv,
    input  ppg_pkg::t_reg_bank           i_terms,
    input  logic [ppg_pkg::X_W-1:0]      i_x,
    input  logic [ppg_pkg::X_W-1:0]      i_y,
    input  logic [ppg_pkg::T_W-1:0]      i_t,
    output logic [ppg_pkg::SINE_AW-1:0]  o_idx [ppg_pkg::NUM_LOOKUPS]
);

    for (genvar k = 0; k < ppg_pkg::NUM_LOOKUPS; k++) begin : g_term
        localparam int CH   = k / ppg_pkg::NUM_TERMS;
        localparam int TM   = k % ppg_pkg::NUM_TERMS;
        localparam int RG   = 2 * CH + TM / 2;
        localparam int SLOT = TM % 2;
        localparam int CB   = ppg_pkg::COEF_BITS;

        logic signed [CB-1:0]                 w_a;
        logic signed [CB-1:0]                 w_b;
        logic signed [CB-1:0]                 w_c;
        logic signed [ppg_pkg::AY_W-1:0]      r_ay;
        logic signed [ppg_pkg::AY_W-1:0]      r_bx;
        logic signed [ppg_pkg::CT_W-1:0]      r_ct;
        logic signed [ppg_pkg::XY_W-1:0]      w_xy;
        logic signed [ppg_pkg::P_W-1:0]       n_p;
        logic signed [ppg_pkg::P_W-1:0]       r_p;
        logic [ppg_pkg::MAG_W-1:0]            w_low;
        logic [ppg_pkg::MAG_W-1:0]            w_mag;
        logic [ppg_pkg::SINE_AW-1:0]          r_idx;

        assign w_a = i_terms[RG][(3 * SLOT + 0) * CB +: CB];
        assign w_b = i_terms[RG][(3 * SLOT + 1) * CB +: CB];
        assign w_c = i_terms[RG][(3 * SLOT + 2) * CB +: CB];

        // stage 1: coefficient times coordinate
        always_ff @(posedge i_clk) begin
            if (i_adv.s1) begin
                r_ay <= w_a * signed'({1'b0, i_y});
                r_bx <= w_b * signed'({1'b0, i_x});
                r_ct <= w_c * signed'({1'b0, i_t});
            end
        end

        // stage 2: align x/y part to the time scale and add
        assign w_xy = ppg_pkg::XY_W'(r_ay) + ppg_pkg::XY_W'(r_bx);
        assign n_p  = ((ppg_pkg::P_W'(w_xy) * ppg_pkg::P_W'(3)) <<< 8)
                    + ppg_pkg::P_W'(r_ct) * ppg_pkg::P_W'(100);

        always_ff @(posedge i_clk) begin
            if (i_adv.s2) begin
                r_p <= n_p;
            end
        end

        // stage 3: low bits of the magnitude, integer part mod table length
        assign w_low = r_p[ppg_pkg::MAG_W-1:0];
        assign w_mag = r_p[ppg_pkg::P_W-1] ? (~w_low + ppg_pkg::MAG_W'(1)) : w_low;

        always_ff @(posedge i_clk) begin
            if (i_adv.s3) begin
                r_idx <= w_mag[ppg_pkg::MAG_W-1 -: ppg_pkg::SINE_AW];
            end
        end

        assign o_idx[k] = r_idx;
    end

endmodule

>>> src/ppg_sine.sv
// ----------------------------------------------------------------------------
// ppg_sine
// Stage 4: sine lookup for every term from the quarter-wave table.
// ----------------------------------------------------------------------------
module ppg_sine (
    input  logic                                i_clk,
    input  ppg_pkg::t_adv                       i_adv,
    input  logic [ppg_pkg::SINE_AW-1:0]         i_idx [ppg_pkg::NUM_LOOKUPS],
    output logic signed [ppg_pkg::SINE_W-1:0]   o_sin [ppg_pkg::NUM_LOOKUPS]
);

    logic signed [ppg_pkg::SINE_W-1:0] r_sin [ppg_pkg::NUM_LOOKUPS];

    always_ff @(posedge i_clk) begin
        if (i_adv.s4) begin
            for (int k = 0; k < ppg_pkg::NUM_LOOKUPS; k++) begin
                r_sin[k] <= ppg_pkg::sine_value(i_idx[k]);
            end
        end
    end

    assign o_sin = r_sin;

endmodule

>>> src/ppg_level.sv
// ----------------------------------------------------------------------------
// ppg_level
// Stages 5-6: sum four terms per channel, then scale to the channel level.
// ----------------------------------------------------------------------------
module ppg_level (
    input  logic                                i_clk,
    input  ppg_pkg::t_adv                       i_adv,
    input  logic signed [ppg_pkg::SINE_W-1:0]   i_sin [ppg_pkg::NUM_LOOKUPS],
    output logic [ppg_pkg::LVL_W-1:0]           o_level [ppg_pkg::NUM_CH]
);

    for (genvar ch = 0; ch < ppg_pkg::NUM_CH; ch++) begin : g_ch
        localparam int B = ch * ppg_pkg::NUM_TERMS;

        logic signed [ppg_pkg::SUM_W-1:0]  r_sum;
        logic [ppg_pkg::SUM_W-1:0]         w_biased;
        logic [ppg_pkg::PROD_W-1:0]        w_prod;
        logic [ppg_pkg::LVL_W-1:0]         r_level;

        // stage 5: channel sum, Q3.14 in -4..4
        always_ff @(posedge i_clk) begin
            if (i_adv.s5) begin
                r_sum <= ppg_pkg::SUM_W'(i_sin[B + 0]) + ppg_pkg::SUM_W'(i_sin[B + 1])
                       + ppg_pkg::SUM_W'(i_sin[B + 2]) + ppg_pkg::SUM_W'(i_sin[B + 3]);
            end
        end

        // stage 6: (sum + 4) * M / 8, never above M
        assign w_biased = ppg_pkg::SUM_W'(r_sum + ppg_pkg::SUM_W'(ppg_pkg::LEVEL_BIAS));
        assign w_prod   = ppg_pkg::PROD_W'(w_biased) * ppg_pkg::PROD_W'(ppg_pkg::LEVEL_M[ch]);

        always_ff @(posedge i_clk) begin
            if (i_adv.s6) begin
                r_level <= w_prod[ppg_pkg::LEVEL_SHIFT +: ppg_pkg::LVL_W];
            end
        end

        assign o_level[ch] = r_level;
    end

endmodule
